FILE: rtl/ptrap_pkg.sv
// Shared types, constants and the arctangent table of the pose integrator.
`timescale 1ns / 1ps
package ptrap_pkg;

  localparam int CW  = 33;  // CORDIC vector width
  localparam int ZW  = 26;  // CORDIC residual angle width
  localparam logic signed [CW-1:0] GAIN_Q30 = 33'sd652032874;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_VMUL,
    ST_SUM,
    ST_HMUL
  } ptrap_state_t;

  typedef struct packed {
    logic cor_start;
    logic vm_start;
    logic hm_start;
    logic update;
  } ptrap_ctrl_t;

  // Arctangent of 2^-i in units of 2^24 per turn.
  function automatic logic [21:0] arc_at(input logic [4:0] i);
    logic [21:0] r;
    case (i)
      5'd0:    r = 22'd2097152;
      5'd1:    r = 22'd1238021;
      5'd2:    r = 22'd654136;
      5'd3:    r = 22'd332050;
      5'd4:    r = 22'd166669;
      5'd5:    r = 22'd83416;
      5'd6:    r = 22'd41718;
      5'd7:    r = 22'd20860;
      5'd8:    r = 22'd10430;
      5'd9:    r = 22'd5215;
      5'd10:   r = 22'd2608;
      5'd11:   r = 22'd1304;
      5'd12:   r = 22'd652;
      5'd13:   r = 22'd326;
      5'd14:   r = 22'd163;
      5'd15:   r = 22'd81;
      5'd16:   r = 22'd41;
      5'd17:   r = 22'd20;
      5'd18:   r = 22'd10;
      5'd19:   r = 22'd5;
      5'd20:   r = 22'd3;
      5'd21:   r = 22'd1;
      5'd22:   r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/ptrap_sermul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module ptrap_sermul #(
  parameter int AW      = 33,
  parameter int BW      = 16,
  parameter bit BSIGNED = 1'b1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [AW-1:0]    a,
  input  logic        [BW-1:0]    b,
  output logic                    done,
  output logic signed [AW+BW-1:0] p
);
  localparam int PW  = AW + BW;
  localparam int CNW = (BW > 1) ? $clog2(BW) : 1;

  logic signed [PW-1:0] a_sh;
  logic        [BW-1:0] b_sh;
  logic        [CNW-1:0] cnt;
  logic                  run;
  logic                  last;

  assign last = (cnt == CNW'(BW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= PW'(a);
      b_sh <= b;
      p    <= '0;
    end else if (run) begin
      // The sign bit of a two's complement multiplier weighs negative.
      if (b_sh[0]) begin
        if (BSIGNED && last) begin
          p <= p - a_sh;
        end else begin
          p <= p + a_sh;
        end
      end
      a_sh <= a_sh <<< 1;
      b_sh <= b_sh >> 1;
    end
  end
endmodule

FILE: rtl/ptrap_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
`timescale 1ns / 1ps
module ptrap_cordic #(
  parameter int STEPS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [15:0]                     angle,
  output logic                            done,
  output logic signed [ptrap_pkg::CW-1:0] cos_out,
  output logic signed [ptrap_pkg::CW-1:0] sin_out
);
  import ptrap_pkg::*;

  localparam int IW = $clog2(STEPS);

  logic signed [CW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic [IW-1:0]        i;
  logic                 run;
  logic                 flip;
  logic [15:0]          folded;
  logic                 need_flip;
  logic signed [CW-1:0] x_sh, y_sh, x_new, y_new;
  logic signed [ZW-1:0] arc;

  // Angles in the back half-circle are turned by half a turn and the result negated.
  assign need_flip = (angle >= 16'd16384) && (angle < 16'd49152);
  assign folded    = need_flip ? angle + 16'd32768 : angle;

  assign x_sh = x >>> i;
  assign y_sh = y >>> i;
  assign arc  = ZW'(arc_at(5'(i)));
  assign x_new = (z >= 0) ? x - y_sh : x + y_sh;
  assign y_new = (z >= 0) ? y + x_sh : y - x_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        i   <= '0;
      end else if (run) begin
        i <= i + 1'b1;
        if (i == IW'(STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= GAIN_Q30;
      y    <= '0;
      z    <= {{(ZW-24){folded[15]}}, folded, 8'd0};
      flip <= need_flip;
    end else if (run) begin
      x <= x_new;
      y <= y_new;
      z <= (z >= 0) ? z - arc : z + arc;
    end
  end

  assign cos_out = flip ? -x : x;
  assign sin_out = flip ? -y : y;
endmodule

FILE: rtl/planar_pose_trapezoid_integrator.sv
// Top level of the planar pose dead-reckoning integrator.
`timescale 1ns / 1ps
// Keeps the pose of NUM_BODIES bodies and advances it by the trapezoidal rule. Each input
// word names a body; the block answers with one word carrying the pose held before the step
// (or as loaded), taken from the output register at once, while the update runs behind it.
// A load word is finished in the cycle it is accepted. An advance word keeps the input stalled
// while the update runs through the iterative CORDIC, the bit-serial speed multipliers, a
// summing state and the bit-serial time-step multipliers, in that order. A new word is taken
// only when the update is finished and the output register is free or being emptied.
module planar_pose_trapezoid_integrator #(
  parameter int NUM_BODIES   = 2,
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data,   // time_step
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // body[0], speed[16:1], turn_rate[40:17], load_x[72:41], load_y[104:73],
  // load_heading[120:105], zero fill up to 127
  input  logic [127:0] s_axis_tdata,
  input  logic         s_axis_tuser,  // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_body[0], pos_x[32:1], pos_y[64:33], heading[80:65], zero fill up to 87
  output logic [87:0]  m_axis_tdata
);
  import ptrap_pkg::*;

  localparam int IDX_W = (NUM_BODIES > 1) ? $clog2(NUM_BODIES) : 1;

  logic [15:0] time_step;
  logic signed [31:0] x_mem [NUM_BODIES];
  logic signed [31:0] y_mem [NUM_BODIES];
  logic        [15:0] h_mem [NUM_BODIES];
  logic signed [31:0] pvx_mem [NUM_BODIES];
  logic signed [31:0] pvy_mem [NUM_BODIES];
  logic signed [23:0] pt_mem [NUM_BODIES];

  ptrap_state_t state, state_next;
  ptrap_ctrl_t  ctrl;

  logic               in_acc, body_ok, is_load;
  logic               in_body;
  logic signed [15:0] in_speed;
  logic signed [23:0] in_turn;
  logic signed [31:0] in_lx, in_ly;
  logic [15:0]        in_lh;
  logic [IDX_W-1:0]   in_idx;

  logic [IDX_W-1:0]   idx;
  logic signed [15:0] speed;
  logic signed [23:0] turn;
  logic signed [31:0] vx, vy;

  logic                 cor_done;
  logic signed [CW-1:0] cor_c, cor_s;
  logic                 vmx_done, vmy_done, hmx_done, hmy_done, hmt_done;
  logic signed [CW+15:0] vpx, vpy;
  logic signed [48:0]    hpx, hpy, vrx, vry, tx, ty;
  logic signed [40:0]    hpt, tt;
  logic signed [32:0]    sum_x, sum_y;
  logic signed [24:0]    sum_t;
  logic signed [33:0]    nx, ny;
  logic signed [31:0]    sat_x, sat_y;

  assign in_body  = s_axis_tdata[0];
  assign in_speed = s_axis_tdata[16:1];
  assign in_turn  = s_axis_tdata[40:17];
  assign in_lx    = s_axis_tdata[72:41];
  assign in_ly    = s_axis_tdata[104:73];
  assign in_lh    = s_axis_tdata[120:105];
  assign in_idx   = IDX_W'(in_body);
  assign is_load  = s_axis_tuser;
  assign body_ok  = (int'(in_body) < NUM_BODIES);

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE) && (!m_axis_tvalid || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= 16'd655;
    end else if (cfg_valid && cfg_ready) begin
      time_step <= cfg_data;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_acc && body_ok && !is_load) state_next = ST_ROT;
      ST_ROT:  if (cor_done) state_next = ST_VMUL;
      ST_VMUL: if (vmx_done) state_next = ST_SUM;
      ST_SUM:  state_next = ST_HMUL;
      ST_HMUL: if (hmx_done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control strobes.
  always_comb begin
    ctrl = '0;
    case (state)
      ST_IDLE: ctrl.cor_start = in_acc && body_ok && !is_load;
      ST_ROT:  ctrl.vm_start  = cor_done;
      ST_SUM:  ctrl.hm_start  = 1'b1;
      ST_HMUL: ctrl.update    = hmx_done;
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx   <= in_idx;
      speed <= in_speed;
      turn  <= in_turn;
    end
    if (vmx_done) begin
      vx <= vrx[48:17];
      vy <= vry[48:17];
    end
  end

  ptrap_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(ctrl.cor_start), .angle(h_mem[in_idx]),
    .done(cor_done), .cos_out(cor_c), .sin_out(cor_s)
  );

  ptrap_sermul #(.AW(CW), .BW(16), .BSIGNED(1'b1)) u_vmx (
    .clk(clk), .rst(rst), .start(ctrl.vm_start), .a(cor_c), .b(speed),
    .done(vmx_done), .p(vpx)
  );
  ptrap_sermul #(.AW(CW), .BW(16), .BSIGNED(1'b1)) u_vmy (
    .clk(clk), .rst(rst), .start(ctrl.vm_start), .a(cor_s), .b(speed),
    .done(vmy_done), .p(vpy)
  );

  // Round the Q.30 by Q8.8 product to Q16.16; the top bits are sign copies.
  assign vrx = (vpx + 49'sd2097152) >>> 5;
  assign vry = (vpy + 49'sd2097152) >>> 5;

  assign sum_x = 33'(vx) + 33'(pvx_mem[idx]);
  assign sum_y = 33'(vy) + 33'(pvy_mem[idx]);
  assign sum_t = 25'(turn) + 25'(pt_mem[idx]);

  ptrap_sermul #(.AW(33), .BW(16), .BSIGNED(1'b0)) u_hmx (
    .clk(clk), .rst(rst), .start(ctrl.hm_start), .a(sum_x), .b(time_step),
    .done(hmx_done), .p(hpx)
  );
  ptrap_sermul #(.AW(33), .BW(16), .BSIGNED(1'b0)) u_hmy (
    .clk(clk), .rst(rst), .start(ctrl.hm_start), .a(sum_y), .b(time_step),
    .done(hmy_done), .p(hpy)
  );
  ptrap_sermul #(.AW(25), .BW(16), .BSIGNED(1'b0)) u_hmt (
    .clk(clk), .rst(rst), .start(ctrl.hm_start), .a(sum_t), .b(time_step),
    .done(hmt_done), .p(hpt)
  );

  // Halve and scale by h with rounding, then add; the position saturates, the heading wraps.
  assign tx = hpx + 49'sd65536;
  assign ty = hpy + 49'sd65536;
  assign tt = hpt + 41'sd65536;
  assign nx = 34'(x_mem[idx]) + 34'($signed(tx[48:17]));
  assign ny = 34'(y_mem[idx]) + 34'($signed(ty[48:17]));
  assign sat_x = (nx[33:31] == 3'b000 || nx[33:31] == 3'b111) ? nx[31:0] :
                 (nx[33] ? 32'sh8000_0000 : 32'sh7fff_ffff);
  assign sat_y = (ny[33:31] == 3'b000 || ny[33:31] == 3'b111) ? ny[31:0] :
                 (ny[33] ? 32'sh8000_0000 : 32'sh7fff_ffff);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_BODIES; k++) begin
        x_mem[k]   <= '0;
        y_mem[k]   <= '0;
        h_mem[k]   <= '0;
        pvx_mem[k] <= '0;
        pvy_mem[k] <= '0;
        pt_mem[k]  <= '0;
      end
    end else if (in_acc && body_ok && is_load) begin
      x_mem[in_idx]   <= in_lx;
      y_mem[in_idx]   <= in_ly;
      h_mem[in_idx]   <= in_lh;
      pvx_mem[in_idx] <= '0;
      pvy_mem[in_idx] <= '0;
      pt_mem[in_idx]  <= '0;
    end else if (ctrl.update) begin
      x_mem[idx]   <= sat_x;
      y_mem[idx]   <= sat_y;
      h_mem[idx]   <= h_mem[idx] + tt[32:17];
      pvx_mem[idx] <= vx;
      pvy_mem[idx] <= vy;
      pt_mem[idx]  <= turn;
    end
  end

  // Output register; the reported pose is the one held before the step, or the loaded one.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_acc) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      m_axis_tdata[87:81] <= '0;
      m_axis_tdata[0]     <= in_body;
      if (!body_ok) begin
        m_axis_tdata[80:1] <= '0;
      end else if (is_load) begin
        m_axis_tdata[80:1] <= {in_lh, in_ly, in_lx};
      end else begin
        m_axis_tdata[80:1] <= {h_mem[in_idx], y_mem[in_idx], x_mem[in_idx]};
      end
    end
  end

  ast_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == ST_IDLE) else $error("input taken while busy");
  ast_adv_starts: assert property (@(posedge clk) disable iff (rst)
    (in_acc && body_ok && !is_load) |=> state == ST_ROT)
    else $error("advance word did not start the CORDIC");
  ast_cor_done: assert property (@(posedge clk) disable iff (rst)
    cor_done |-> state == ST_ROT) else $error("CORDIC finished out of turn");
  ast_mul_lockstep: assert property (@(posedge clk) disable iff (rst)
    (vmx_done == vmy_done) && (hmx_done == hmy_done) && (hmx_done == hmt_done))
    else $error("serial multipliers out of step");
endmodule

FILE: tb/sv/planar_pose_trapezoid_integrator_tb.sv
// Self-checking bench for the planar pose trapezoid integrator.
`timescale 1ns / 1ps
module planar_pose_trapezoid_integrator_tb;
  localparam int NBODY = 2;
  localparam int NSTEP = 16;
  localparam bit MODE_ADVANCE = 1'b0;
  localparam bit MODE_LOAD = 1'b1;
  localparam int CFG_TIME_STEP = 0;
  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 1500;

  typedef struct packed {
    logic        mode;
    logic        body;
    logic [15:0] speed;
    logic [23:0] turn;
    logic [31:0] lx;
    logic [31:0] ly;
    logic [15:0] lh;
  } tick_t;

  typedef struct packed {
    logic        body;
    logic [31:0] px;
    logic [31:0] py;
    logic [15:0] hd;
  } pose_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [87:0] m_axis_tdata;

  planar_pose_trapezoid_integrator #(.NUM_BODIES(NBODY), .CORDIC_STEPS(NSTEP)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state, one set per body.
  logic [15:0] step_h;
  logic signed [31:0] px_q [NBODY];
  logic signed [31:0] py_q [NBODY];
  logic [15:0] hd_q [NBODY];
  logic signed [31:0] pvx_q [NBODY];
  logic signed [31:0] pvy_q [NBODY];
  logic signed [23:0] pturn_q [NBODY];

  tick_t pending_ticks[$];
  pose_t expected_poses[$];
  int errors = 0;
  int n_results = 0;
  int n_loads = 0;
  int n_advances = 0;
  int idle_cycles = 0;
  bit stim_done = 0;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void cordic_rot(input logic [15:0] ang, output longint c,
                                     output longint s);
    longint x, y, z, nx;
    logic [15:0] a;
    bit flip;
    longint arc [16] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                         10430, 5215, 2608, 1304, 652, 326, 163, 81};
    a = ang;
    flip = 0;
    x = 652032874;
    y = 0;
    if (a >= 16'd16384 && a < 16'd49152) begin
      a = a + 16'd32768;
      flip = 1;
    end
    z = longint'($signed(a)) * 256;
    for (int i = 0; i < NSTEP; i++) begin
      if (z >= 0) begin
        nx = x - asr(y, i);
        y = y + asr(x, i);
        z -= arc[i];
      end else begin
        nx = x + asr(y, i);
        y = y - asr(x, i);
        z += arc[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint trap_step(longint rate, longint prev, logic [15:0] h);
    return asr((rate + prev) * longint'(h) + 65536, 17);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic pose_t advance_pose(tick_t t);
    pose_t r;
    int b;
    longint c, s, vx, vy, sp, tr;
    b = t.body;
    r.body = t.body;
    if (t.mode == MODE_LOAD) begin
      px_q[b] = t.lx;
      py_q[b] = t.ly;
      hd_q[b] = t.lh;
      pvx_q[b] = 0;
      pvy_q[b] = 0;
      pturn_q[b] = 0;
    end
    r.px = px_q[b];
    r.py = py_q[b];
    r.hd = hd_q[b];
    if (t.mode == MODE_ADVANCE) begin
      sp = longint'($signed(t.speed));
      tr = longint'($signed(t.turn));
      cordic_rot(hd_q[b], c, s);
      vx = asr(sp * c + (64'sd1 << 21), 22);
      vy = asr(sp * s + (64'sd1 << 21), 22);
      px_q[b] = clamp32(longint'(px_q[b]) + trap_step(vx, pvx_q[b], step_h));
      py_q[b] = clamp32(longint'(py_q[b]) + trap_step(vy, pvy_q[b], step_h));
      hd_q[b] = hd_q[b] + 16'(trap_step(tr, pturn_q[b], step_h));
      pvx_q[b] = vx[31:0];
      pvy_q[b] = vy[31:0];
      pturn_q[b] = t.turn;
    end
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Rebuilds an input item from the mode flag and the packed data word.
  function automatic tick_t unpack_tick(logic mode, logic [127:0] d);
    tick_t t;
    t.mode  = mode;
    t.body  = d[0];
    t.speed = d[16:1];
    t.turn  = d[40:17];
    t.lx    = d[72:41];
    t.ly    = d[104:73];
    t.lh    = d[120:105];
    return t;
  endfunction

  // Idling is switched off for stretches so that back-to-back words occur too.
  bit calm_phase = 0;

  // Input driver.
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_poses.push_back(advance_pose(unpack_tick(s_axis_tuser, s_axis_tdata)));
        if (s_axis_tuser) n_loads++;
        else n_advances++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          s_axis_tvalid <= 0;
        end else if (pending_ticks.size() > 0) begin
          tick_t t;
          t = pending_ticks.pop_front();
          s_axis_tvalid <= 1;
          s_axis_tuser <= t.mode;
          s_axis_tdata <= {7'b0, t.lh, t.ly, t.lx, t.turn, t.speed, t.body};
          in_gap <= calm_phase ? 0 : gap_len();
        end else begin
          s_axis_tvalid <= 0;
        end
      end
    end
  end

  // Output monitor with random back-pressure.
  int out_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        pose_t got, want;
        got = {m_axis_tdata[0], m_axis_tdata[32:1], m_axis_tdata[64:33],
               m_axis_tdata[80:65]};
        n_results++;
        if (expected_poses.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          errors++;
        end else begin
          want = expected_poses.pop_front();
          if (got.body != want.body) begin
            $display("%0t: out_body exp %0d got %0d", $time, want.body, got.body);
            errors++;
          end
          if (got.px != want.px) begin
            $display("%0t: pos_x exp %h got %h", $time, want.px, got.px);
            errors++;
          end
          if (got.py != want.py) begin
            $display("%0t: pos_y exp %h got %h", $time, want.py, got.py);
            errors++;
          end
          if (got.hd != want.hd) begin
            $display("%0t: heading exp %h got %h", $time, want.hd, got.hd);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 1;
        if (!calm_phase) out_gap <= gap_len();
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready) || stim_done)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_ticks.size() > 0 || s_axis_tvalid || expected_poses.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_step(logic [15:0] h);
    cfg_valid <= 1;
    cfg_data <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (CFG_TIME_STEP == 0) step_h = h;
  endtask

  function automatic tick_t rand_tick(bit load);
    tick_t t;
    t.mode = load;
    t.body = 1'($urandom_range(0, 1));
    t.speed = 16'($urandom());
    t.turn = 24'($urandom());
    t.lx = $urandom();
    t.ly = $urandom();
    t.lh = 16'($urandom());
    // Mostly moderate magnitudes keep the poses inside range for long runs.
    if ($urandom_range(0, 3) != 0) begin
      t.speed = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
      t.turn = $signed(24'($urandom_range(0, 65535))) - 24'sd32768;
      t.lx = $signed(32'($urandom_range(0, 1 << 24))) - 32'sd8388608;
      t.ly = $signed(32'($urandom_range(0, 1 << 24))) - 32'sd8388608;
    end
    return t;
  endfunction

  function automatic tick_t mk(bit m, bit b, logic [15:0] sp, logic [23:0] tr,
                               logic [31:0] lx, logic [31:0] ly, logic [15:0] lh);
    tick_t t;
    t = '{m, b, sp, tr, lx, ly, lh};
    return t;
  endfunction

  initial begin
    logic [15:0] steps [5] = '{16'd655, 16'd1, 16'd65535, 16'd4096, 16'd30000};
    step_h = 16'd655;
    for (int i = 0; i < NBODY; i++) begin
      px_q[i] = 0; py_q[i] = 0; hd_q[i] = 0;
      pvx_q[i] = 0; pvy_q[i] = 0; pturn_q[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset pose, extremes of speed and turn, heading quadrants, saturation.
    pending_ticks.push_back(mk(MODE_ADVANCE, 0, 16'h7fff, 24'h7fffff, 0, 0, 0));
    pending_ticks.push_back(mk(MODE_ADVANCE, 0, 16'h8000, 24'h800000, 0, 0, 0));
    pending_ticks.push_back(mk(MODE_ADVANCE, 1, 16'h0100, 24'h000100, 0, 0, 0));
    pending_ticks.push_back(mk(MODE_LOAD, 1, 0, 0, 32'h7fff0000, 32'h80010000, 16'h4000));
    pending_ticks.push_back(mk(MODE_ADVANCE, 1, 16'h7fff, 24'h0, 0, 0, 0));
    pending_ticks.push_back(mk(MODE_ADVANCE, 1, 16'h8000, 24'h0, 0, 0, 0));
    pending_ticks.push_back(mk(MODE_LOAD, 0, 16'hffff, 24'hffffff, 32'h7fffffff,
                               32'h7fffffff, 16'hffff));
    pending_ticks.push_back(mk(MODE_ADVANCE, 0, 16'h7fff, 24'h7fffff, 0, 0, 0));
    pending_ticks.push_back(mk(MODE_ADVANCE, 0, 16'h7fff, 24'h7fffff, 0, 0, 0));
    pending_ticks.push_back(mk(MODE_LOAD, 0, 0, 0, 32'h80000000, 32'h80000000, 16'h8000));
    pending_ticks.push_back(mk(MODE_ADVANCE, 0, 16'h7fff, 24'h0, 0, 0, 0));
    pending_ticks.push_back(mk(MODE_ADVANCE, 0, 16'h7fff, 24'h0, 0, 0, 0));
    pending_ticks.push_back(mk(MODE_LOAD, 1, 0, 0, 0, 0, 16'hc000));
    pending_ticks.push_back(mk(MODE_ADVANCE, 1, 16'h1234, 24'h123456, 0, 0, 0));
    pending_ticks.push_back(mk(MODE_LOAD, 0, 0, 0, 0, 0, 16'h3fff));
    pending_ticks.push_back(mk(MODE_ADVANCE, 0, 16'h0100, 24'hffff00, 0, 0, 0));
    pending_ticks.push_back(mk(MODE_LOAD, 0, 0, 0, 0, 0, 16'hbfff));
    pending_ticks.push_back(mk(MODE_ADVANCE, 0, 16'hff00, 24'h000001, 0, 0, 0));
    wait_drained();

    // Random phases, each under its own time step, extremes included.
    for (int p = 0; p < 5; p++) begin
      write_step(steps[p]);
      calm_phase = (p == 2);
      for (int n = 0; n < N_RANDOM / 5; n++)
        pending_ticks.push_back(rand_tick($urandom_range(0, 9) == 0));
      wait_drained();
    end
    stim_done = 1;

    $display("tb: %0d loads and %0d advances over 5 time-step settings", n_loads,
             n_advances);
    $display("tb: %0d result words checked, %0d mismatches", n_results, errors);
    if (errors == 0 && expected_poses.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
